// ===== rtl/dfm_pkg.sv =====
`default_nettype none

package dfm_pkg;

  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 512;
  localparam int FRAME_CELLS  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_CELLS);

  localparam int PIX_W    = 9;
  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 10;
  localparam int BOUND_W  = 20;
  localparam int MODE_W   = 3;
  localparam int REG_IDX_W = 3;

  typedef enum logic {
    CMD_CAPTURE  = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_t;

  localparam logic [REG_IDX_W-1:0] REG_ROI_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROI_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THR_MIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THR_MAX    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ELL_CENTER = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ELL_RADII  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd6;

  localparam int MODE_IR      = 0;
  localparam int MODE_FLIP    = 1;
  localparam int MODE_ELLIPSE = 2;

  typedef struct packed {
    cmd_t                cmd;
    logic [PIX_W-1:0]    pix_x;
    logic [PIX_W-1:0]    pix_y;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic             foreground;
    logic [PIX_W-1:0] out_x;
    logic [PIX_W-1:0] out_y;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/depth_foreground_mask.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Beat
// item      in         item_valid / item_stall   cmd, pix_x, pix_y, sample
// result    out        result_valid / result_stall  foreground, out_x, out_y
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is taken every cycle while item_stall is low; a capture writes the background
// store at acceptance. A classify reads the store at acceptance and reaches the result
// register through the first stage (the read), then two multiplier stages and a compare.
// Reset clears the pipeline valids and presets the config; the background store is not cleared.
// A stall on the result side backs up through the stages, and item_stall rises only
// when the first stage is occupied and cannot move.

module depth_foreground_mask (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire dfm_pkg::in_item_t             item,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output dfm_pkg::out_item_t                 result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dfm_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [dfm_pkg::BOUND_W-1:0]   cfg_data
);
  import dfm_pkg::*;

  localparam logic [PIX_W-1:0] X_MAX = PIX_W'(FRAME_WIDTH - 1);
  localparam logic [COORD_W:0] FW    = (COORD_W + 1)'(FRAME_WIDTH);
  localparam logic [COORD_W:0] FH    = (COORD_W + 1)'(FRAME_HEIGHT);

  logic [BOUND_W-1:0]  roi_x;
  logic [BOUND_W-1:0]  roi_y;
  logic [SAMPLE_W-1:0] thr_min;
  logic [SAMPLE_W-1:0] thr_max;
  logic [BOUND_W-1:0]  ell_center;
  logic [BOUND_W-1:0]  ell_radii;
  logic [MODE_W-1:0]   mode;

  logic [SAMPLE_W-1:0] bg_mem [FRAME_CELLS];
  logic [SAMPLE_W-1:0] bg_rd;

  logic                item_acc;
  logic                in_frame0;
  logic [ADDR_W-1:0]   addr0;
  logic [PIX_W-1:0]    ox0;

  logic                rdy_o, rdy3, rdy2, rdy1;

  logic                s1_valid;
  logic                s1_in_frame;
  logic [PIX_W-1:0]    s1_x;
  logic [PIX_W-1:0]    s1_y;
  logic [PIX_W-1:0]    s1_ox;
  logic [SAMPLE_W-1:0] s1_s;

  logic [SAMPLE_W-1:0] s1_diff;
  logic                s1_pre;
  logic [COORD_W-1:0]  s1_dx;
  logic [COORD_W-1:0]  s1_dy;

  logic                  s2_valid;
  logic                  s2_pre;
  logic                  s2_rzero;
  logic [2*COORD_W-1:0]  s2_dx2;
  logic [2*COORD_W-1:0]  s2_dy2;
  logic [2*COORD_W-1:0]  s2_rx2;
  logic [2*COORD_W-1:0]  s2_ry2;
  logic [PIX_W-1:0]      s2_ox;
  logic [PIX_W-1:0]      s2_y;

  logic                  s3_valid;
  logic                  s3_pre;
  logic                  s3_rzero;
  logic [4*COORD_W-1:0]  s3_px;
  logic [4*COORD_W-1:0]  s3_py;
  logic [4*COORD_W-1:0]  s3_pr;
  logic [PIX_W-1:0]      s3_ox;
  logic [PIX_W-1:0]      s3_y;

  logic [4*COORD_W:0]    s3_sum;
  logic                  s3_fg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_x      <= BOUND_W'(512 << 10);
      roi_y      <= BOUND_W'(512 << 10);
      thr_min    <= '0;
      thr_max    <= '1;
      ell_center <= BOUND_W'((256 << 10) | 256);
      ell_radii  <= BOUND_W'((256 << 10) | 256);
      mode       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROI_X:      roi_x      <= cfg_data;
        REG_ROI_Y:      roi_y      <= cfg_data;
        REG_THR_MIN:    thr_min    <= cfg_data[SAMPLE_W-1:0];
        REG_THR_MAX:    thr_max    <= cfg_data[SAMPLE_W-1:0];
        REG_ELL_CENTER: ell_center <= cfg_data;
        REG_ELL_RADII:  ell_radii  <= cfg_data;
        REG_MODE:       mode       <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign rdy_o      = !result_valid || !result_stall;
  assign rdy3       = !s3_valid || rdy_o;
  assign rdy2       = !s2_valid || rdy3;
  assign rdy1       = !s1_valid || rdy2;
  assign item_stall = !rdy1;
  assign item_acc   = item_valid && rdy1;

  assign in_frame0 = ({2'b00, item.pix_x} < FW) && ({2'b00, item.pix_y} < FH);
  assign addr0     = ADDR_W'(int'(item.pix_y) * FRAME_WIDTH + int'(item.pix_x));
  assign ox0       = mode[MODE_FLIP] ? X_MAX - item.pix_x : item.pix_x;

  always_ff @(posedge clk) begin
    if (item_acc && item.cmd == CMD_CAPTURE && in_frame0) begin
      bg_mem[addr0] <= item.sample;
    end
    if (item_acc && item.cmd == CMD_CLASSIFY) begin
      bg_rd <= bg_mem[addr0];
    end
  end

  always_comb begin
    if (mode[MODE_IR]) begin
      s1_diff = s1_s - bg_rd;
    end else begin
      s1_diff = bg_rd - s1_s;
    end
    s1_pre = s1_in_frame && (s1_s != '0) &&
             (s1_diff > thr_min) && (s1_diff < thr_max) &&
             ({1'b0, s1_ox} >= roi_x[COORD_W-1:0]) &&
             ({1'b0, s1_ox} < roi_x[BOUND_W-1:COORD_W]) &&
             ({1'b0, s1_y} >= roi_y[COORD_W-1:0]) &&
             ({1'b0, s1_y} < roi_y[BOUND_W-1:COORD_W]);
    if (ell_center[COORD_W-1:0] >= {1'b0, s1_x}) begin
      s1_dx = ell_center[COORD_W-1:0] - {1'b0, s1_x};
    end else begin
      s1_dx = {1'b0, s1_x} - ell_center[COORD_W-1:0];
    end
    if (ell_center[BOUND_W-1:COORD_W] >= {1'b0, s1_y}) begin
      s1_dy = ell_center[BOUND_W-1:COORD_W] - {1'b0, s1_y};
    end else begin
      s1_dy = {1'b0, s1_y} - ell_center[BOUND_W-1:COORD_W];
    end
  end

  assign s3_sum = {1'b0, s3_px} + {1'b0, s3_py};
  assign s3_fg  = s3_pre && (!mode[MODE_ELLIPSE] || (!s3_rzero && (s3_sum < {1'b0, s3_pr})));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid <= item_acc && item.cmd == CMD_CLASSIFY;
      end
      if (rdy2) begin
        s2_valid <= s1_valid;
      end
      if (rdy3) begin
        s3_valid <= s2_valid;
      end
      if (rdy_o) begin
        result_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_in_frame <= in_frame0;
      s1_x        <= item.pix_x;
      s1_y        <= item.pix_y;
      s1_ox       <= ox0;
      s1_s        <= item.sample;
    end
    if (rdy2) begin
      s2_pre   <= s1_pre;
      s2_rzero <= (ell_radii[COORD_W-1:0] == '0) || (ell_radii[BOUND_W-1:COORD_W] == '0);
      s2_dx2   <= s1_dx * s1_dx;
      s2_dy2   <= s1_dy * s1_dy;
      s2_rx2   <= ell_radii[COORD_W-1:0] * ell_radii[COORD_W-1:0];
      s2_ry2   <= ell_radii[BOUND_W-1:COORD_W] * ell_radii[BOUND_W-1:COORD_W];
      s2_ox    <= s1_ox;
      s2_y     <= s1_y;
    end
    if (rdy3) begin
      s3_pre   <= s2_pre;
      s3_rzero <= s2_rzero;
      s3_px    <= s2_dx2 * s2_ry2;
      s3_py    <= s2_dy2 * s2_rx2;
      s3_pr    <= s2_rx2 * s2_ry2;
      s3_ox    <= s2_ox;
      s3_y     <= s2_y;
    end
    if (rdy_o) begin
      result.foreground <= s3_fg;
      result.out_x      <= s3_ox;
      result.out_y      <= s3_y;
    end
  end

  a_stall_needs_s1 : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("item stall raised with an empty first stage");

  a_classify_enters : assert property (@(posedge clk) disable iff (rst)
    (item_acc && item.cmd == CMD_CLASSIFY) |=> s1_valid)
    else $error("accepted classify beat did not enter the pipeline");

  a_capture_bubble : assert property (@(posedge clk) disable iff (rst)
    (item_acc && item.cmd == CMD_CAPTURE) |=> !s1_valid)
    else $error("capture beat produced a pipeline entry");

  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s3_valid))
    else $error("result appeared without a last-stage entry");

endmodule

`default_nettype wire
